### rtl/cab_pkg.sv
// Shared types and codes for the complement-acknowledge block receiver.
`timescale 1ns / 1ps

package cab_pkg;

    localparam int KIND_W = 3;

    localparam logic [KIND_W-1:0] KIND_LENGTH   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SEQUENCE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TITLE    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TRAILER  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ECHO     = 3'd5;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT  = 3'd6;

    // Configuration register indexes.
    localparam logic CFG_USE_SEQ = 1'b0;
    localparam logic CFG_ECHO    = 1'b1;

    typedef struct packed {
        logic       timed_out;
        logic [7:0] line_byte;
    } t_in;

    typedef struct packed {
        logic              block_done;
        logic [7:0]        ack_byte;
        logic              ack_valid;
        logic [7:0]        data_byte;
        logic [KIND_W-1:0] byte_kind;
    } t_res;

endpackage

### rtl/cab_class.sv
// Position tracking and byte classification for one received line byte.
`timescale 1ns / 1ps

module cab_class (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  cab_pkg::t_in  i_item,
    input  logic          i_use_seq,
    input  logic          i_echo,
    output cab_pkg::t_res o_res
);

    logic [7:0] r_pos, n_pos;
    logic [7:0] r_len, n_len;
    logic       r_loop, n_loop;

    logic [7:0] title_pos;

    always_comb begin
        title_pos = i_use_seq ? 8'd2 : 8'd1;
        n_pos     = r_pos;
        n_len     = r_len;
        n_loop    = r_loop;

        o_res.byte_kind  = cab_pkg::KIND_PAYLOAD;
        o_res.data_byte  = i_item.line_byte;
        o_res.ack_valid  = 1'b0;
        o_res.block_done = 1'b0;

        if (i_item.timed_out) begin
            o_res.byte_kind  = cab_pkg::KIND_TIMEOUT;
            o_res.data_byte  = 8'd0;
            o_res.block_done = 1'b1;
            n_pos            = 8'd0;
            n_loop           = 1'b0;
        end else if (r_loop) begin
            o_res.byte_kind = cab_pkg::KIND_ECHO;
            n_loop          = 1'b0;
        end else begin
            if (r_pos == 8'd0) begin
                o_res.byte_kind = cab_pkg::KIND_LENGTH;
                n_len           = i_item.line_byte;
                o_res.ack_valid = i_echo;
                if (i_item.line_byte == 8'd0) begin
                    o_res.block_done = 1'b1;
                end else begin
                    n_pos = 8'd1;
                end
            end else if (r_pos >= r_len) begin
                o_res.byte_kind  = cab_pkg::KIND_TRAILER;
                o_res.block_done = 1'b1;
                n_pos            = 8'd0;
            end else begin
                if (i_use_seq && r_pos == 8'd1) begin
                    o_res.byte_kind = cab_pkg::KIND_SEQUENCE;
                end else if (r_pos == title_pos) begin
                    o_res.byte_kind = cab_pkg::KIND_TITLE;
                end else begin
                    o_res.byte_kind = cab_pkg::KIND_PAYLOAD;
                end
                o_res.ack_valid = i_echo;
                n_pos           = r_pos + 8'd1;
            end
            n_loop = o_res.ack_valid;
        end

        o_res.ack_byte = o_res.ack_valid ? ~i_item.line_byte : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 8'd0;
            r_len  <= 8'd0;
            r_loop <= 1'b0;
        end else if (i_fire) begin
            r_pos  <= n_pos;
            r_len  <= n_len;
            r_loop <= n_loop;
        end
    end

endmodule

### rtl/complement_ack_block_receiver.sv
// Top level of the complement-acknowledge block receiver.
`timescale 1ns / 1ps

// This block receives a length-prefixed block one line byte per item. The
// first byte gives the number of bytes that follow; later bytes are classed
// by position as sequence number (when enabled), title, payload, and the
// final trailer. With echo mode on, every byte but the trailer produces an
// acknowledge byte (its complement), and the following line byte is taken
// as the loopback of that acknowledge and reported as discarded. An item
// with the timeout flag set aborts the block and reports an error. Every
// item gives exactly one result item. An item passes through the input
// register and then the result register, and a new item is taken every
// cycle while the result side keeps up; the position counter updates in
// the same cycle that an item moves from the input register to the result
// register, which is what sets that rate. Configuration writes take effect
// at once, so they should be issued only while no item is in flight.
module complement_ack_block_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic        i_cfg_data,
    // Incoming line bytes.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] line_byte
    input  logic        i_s_axis_tuser,   // [0] timed_out
    // Classified results.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] data_byte, [8] ack_valid,
                                          // [16:9] ack_byte, [23:17] zero
    output logic [2:0]  o_m_axis_tuser,   // [2:0] byte_kind
    output logic        o_m_axis_tlast    // block_done
);

    logic r_use_seq;
    logic r_echo;

    logic          r_in_valid;
    cab_pkg::t_in  r_in;
    logic          r_out_valid;
    cab_pkg::t_res r_out;

    cab_pkg::t_res res;
    logic          out_free;
    logic          move;

    // The result register frees up when it is empty or being taken.
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign move            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_seq <= 1'b1;
            r_echo    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cab_pkg::CFG_USE_SEQ: r_use_seq <= i_cfg_data;
                cab_pkg::CFG_ECHO:    r_echo    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in.line_byte <= i_s_axis_tdata;
            r_in.timed_out <= i_s_axis_tuser;
        end
    end

    cab_class u_class (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (move),
        .i_item    (r_in),
        .i_use_seq (r_use_seq),
        .i_echo    (r_echo),
        .o_res     (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out.ack_byte, r_out.ack_valid, r_out.data_byte};
    assign o_m_axis_tuser  = r_out.byte_kind;
    assign o_m_axis_tlast  = r_out.block_done;

    // An acknowledge always carries the complement of the received byte.
    a_ack_complement: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[8]) |->
            (o_m_axis_tdata[16:9] == ~o_m_axis_tdata[7:0]))
        else $error("ack byte is not the complement of the data byte");

    // A timeout ends the block and is never acknowledged.
    a_timeout_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == cab_pkg::KIND_TIMEOUT) |->
            (o_m_axis_tlast && !o_m_axis_tdata[8] && o_m_axis_tdata[7:0] == 8'd0))
        else $error("timeout result malformed");

    // A trailer ends the block and is never acknowledged.
    a_trailer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == cab_pkg::KIND_TRAILER) |->
            (o_m_axis_tlast && !o_m_axis_tdata[8]))
        else $error("trailer result malformed");

    // A discarded loopback neither ends the block nor asks for an acknowledge.
    a_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == cab_pkg::KIND_ECHO) |->
            (!o_m_axis_tlast && !o_m_axis_tdata[8]))
        else $error("loopback result malformed");

endmodule
